// ===== rtl/pca_pkg.sv =====
// package for the pixel color adjuster: payload types, mode codes, arithmetic constants
`default_nettype none

package pca_pkg;

   localparam int FRACTION_BITS = 12;
   localparam int CHAN_W        = 8;
   localparam int NUM_CHAN      = 3;
   localparam int FACTOR_W      = 16;
   localparam int MODE_W        = 2;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = FACTOR_W;

   // luminance weights scaled by ten thousand, they sum to exactly the scale
   localparam int LUM_R     = 2126;
   localparam int LUM_G     = 7152;
   localparam int LUM_B     = 722;
   localparam int LUM_SCALE = 10000;
   localparam int LUM_W     = 22;

   // multiplier operand and product
   localparam int OPD_W  = 24;
   localparam int PROD_W = FACTOR_W + OPD_W;

   // quotient by LUM_SCALE through a rounded-up reciprocal, exact for all m below the limit
   localparam int M_W         = 22;
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 36;
   localparam int QPROD_W     = M_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(6871948);

   localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

   // saturation limits on the shifted sum
   localparam logic signed [PROD_W-1:0] CHAN_LIMIT = PROD_W'(256);
   localparam logic signed [PROD_W-1:0] SAT_LIMIT  = PROD_W'(256 * LUM_SCALE);
   localparam logic signed [PROD_W-1:0] CONTRAST_BIAS =
      PROD_W'(longint'(255) <<< FRACTION_BITS);

   localparam logic signed [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1 << FRACTION_BITS);

   typedef enum logic [MODE_W-1:0] {
      MODE_PASS     = 2'd0,
      MODE_BRIGHT   = 2'd1,
      MODE_CONTRAST = 2'd2,
      MODE_SATURATE = 2'd3
   } adjust_mode_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FACTOR = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic [CHAN_W-1:0] alpha_in;
      logic              image_end_in;
   } pix_in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic [CHAN_W-1:0] alpha_out;
      logic              image_end_out;
   } pix_out_type;

endpackage

`default_nettype wire

// ===== rtl/pixel_color_adjust.sv =====
// top level of the pixel color adjuster: four-stage pipeline with csr registers
`default_nettype none

// Per-pixel color adjuster for 8-bit RGBA. csr register 0 selects the mode (pass-through,
// brighten x*f, contrast 127.5+f*(x-127.5), saturate (1-f)*L+f*x with Rec.709 luminance L),
// register 1 holds the signed Q4.12 factor f. Every RGB result is the exact floor of the
// adjusted value clamped to 0..255; alpha and the end-of-image mark ride along unchanged.
// One transaction enters per clock unless the result side stalls, and passes through the
// four register stages (luminance and operand, factor multiply, bias/shift/clamp, reciprocal
// divide by ten thousand and output select). A stall on the result side backs up through
// the stages, and an empty stage keeps accepting. Write the csr registers only while the
// pipeline is empty.
module pixel_color_adjust (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire pca_pkg::pix_in_type        req_data,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output pca_pkg::pix_out_type            rsp_data,
   input  wire                             csr_write,
   input  wire [pca_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire [pca_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pca_pkg::*;

   // csr registers
   adjust_mode_type             mode_ff, mode_in;
   logic signed [FACTOR_W-1:0]  factor_ff, factor_in;

   // stage valid bits and move enables
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic en1, en2, en3, en4;

   // stage 1: luminance and multiplier operand
   pix_in_type                 pix1_ff, pix1_in;
   logic [LUM_W-1:0]           lum1_ff, lum1_in;
   logic signed [OPD_W-1:0]    opd1_ff [NUM_CHAN];
   logic signed [OPD_W-1:0]    opd1_in [NUM_CHAN];

   // stage 2: factor products
   pix_in_type                 pix2_ff, pix2_in;
   logic [LUM_W-1:0]           lum2_ff, lum2_in;
   logic signed [PROD_W-1:0]   prod2_ff [NUM_CHAN];
   logic signed [PROD_W-1:0]   prod2_in [NUM_CHAN];

   // stage 3: shifted sum with clamp flags
   pix_in_type                 pix3_ff, pix3_in;
   logic [M_W-1:0]             m3_ff [NUM_CHAN];
   logic [M_W-1:0]             m3_in [NUM_CHAN];
   logic [NUM_CHAN-1:0]        lo3_ff, lo3_in, hi3_ff, hi3_in;

   // stage 4: output register
   pix_out_type                out4_ff, out4_in;

   logic [CHAN_W-1:0]          x0 [NUM_CHAN];
   logic [CHAN_W-1:0]          x2 [NUM_CHAN];
   logic [CHAN_W-1:0]          res [NUM_CHAN];

   assign x0[0] = req_data.red_in;
   assign x0[1] = req_data.green_in;
   assign x0[2] = req_data.blue_in;
   assign x2[0] = pix2_ff.red_in;
   assign x2[1] = pix2_ff.green_in;
   assign x2[2] = pix2_ff.blue_in;

   // ---------------------------------------------------------------- csr
   always_comb begin
      mode_in   = mode_ff;
      factor_in = factor_ff;
      if (csr_write && csr_index == CSR_MODE) begin
         mode_in = adjust_mode_type'(csr_wdata[MODE_W-1:0]);
      end
      if (csr_write && csr_index == CSR_FACTOR) begin
         factor_in = $signed(csr_wdata[FACTOR_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PASS;
         factor_ff <= FACTOR_ONE;
      end else begin
         mode_ff   <= mode_in;
         factor_ff <= factor_in;
      end
   end

   // ---------------------------------------------------------------- flow control
   // a stage moves when it is empty or its successor moves
   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;
   assign rsp_valid = v4_ff;
   assign rsp_data  = out4_ff;

   assign v1_in = en1 ? req_valid : v1_ff;
   assign v2_in = en2 ? v1_ff     : v2_ff;
   assign v3_in = en3 ? v2_ff     : v3_ff;
   assign v4_in = en4 ? v3_ff     : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // luminance times ten thousand, then the operand the factor multiplies:
   //   brighten x, contrast 2x-255, saturate 10000x-lum
   always_comb begin
      pix1_in = pix1_ff;
      lum1_in = lum1_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         opd1_in[c] = opd1_ff[c];
      end
      if (en1) begin
         pix1_in = req_data;
         lum1_in = LUM_W'(LUM_R * int'(x0[0])) + LUM_W'(LUM_G * int'(x0[1]))
                 + LUM_W'(LUM_B * int'(x0[2]));
         for (int c = 0; c < NUM_CHAN; c++) begin
            case (mode_ff)
               MODE_CONTRAST: opd1_in[c] = $signed(OPD_W'({x0[c], 1'b0}))
                                           - $signed(OPD_W'(255));
               MODE_SATURATE: opd1_in[c] = $signed(OPD_W'(LUM_SCALE * int'(x0[c]))
                                           - OPD_W'(lum1_in));
               default:       opd1_in[c] = $signed(OPD_W'(x0[c]));
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      pix2_in = pix2_ff;
      lum2_in = lum2_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod2_in[c] = prod2_ff[c];
      end
      if (en2) begin
         pix2_in = pix1_ff;
         lum2_in = lum1_ff;
         for (int c = 0; c < NUM_CHAN; c++) begin
            prod2_in[c] = factor_ff * opd1_ff[c];
         end
      end
   end

   // ---------------------------------------------------------------- stage 3
   // add the mode bias, floor-shift by the fraction (one more bit in contrast), flag clamp cases
   always_comb begin
      logic signed [PROD_W-1:0] bias;
      logic signed [PROD_W-1:0] sum;
      logic signed [PROD_W-1:0] sh;
      logic signed [PROD_W-1:0] limit;
      bias  = '0;
      sum   = '0;
      sh    = '0;
      limit = CHAN_LIMIT;
      pix3_in = pix3_ff;
      lo3_in  = lo3_ff;
      hi3_in  = hi3_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         m3_in[c] = m3_ff[c];
      end
      if (en3) begin
         pix3_in = pix2_ff;
         case (mode_ff)
            MODE_CONTRAST: bias = CONTRAST_BIAS;
            MODE_SATURATE: bias = $signed(PROD_W'(lum2_ff) << FRACTION_BITS);
            default:       bias = '0;
         endcase
         limit = (mode_ff == MODE_SATURATE) ? SAT_LIMIT : CHAN_LIMIT;
         for (int c = 0; c < NUM_CHAN; c++) begin
            sum = prod2_ff[c] + bias;
            sh  = (mode_ff == MODE_CONTRAST) ? (sum >>> (FRACTION_BITS + 1))
                                             : (sum >>> FRACTION_BITS);
            if (mode_ff == MODE_PASS) begin
               lo3_in[c] = 1'b0;
               hi3_in[c] = 1'b0;
               m3_in[c]  = M_W'(x2[c]);
            end else begin
               lo3_in[c] = sh[PROD_W-1];
               hi3_in[c] = (sh >= limit);
               m3_in[c]  = sh[M_W-1:0];
            end
         end
      end
   end

   // ---------------------------------------------------------------- stage 4
   // saturate mode divides by ten thousand through the reciprocal
   always_comb begin
      logic [QPROD_W-1:0] qprod;
      qprod   = '0;
      out4_in = out4_ff;
      for (int c = 0; c < NUM_CHAN; c++) begin
         res[c] = '0;
      end
      if (en4) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            qprod = QPROD_W'(m3_ff[c]) * QPROD_W'(RECIP);
            if (lo3_ff[c]) begin
               res[c] = '0;
            end else if (hi3_ff[c]) begin
               res[c] = CHAN_MAX;
            end else if (mode_ff == MODE_SATURATE) begin
               res[c] = qprod[RECIP_SHIFT +: CHAN_W];
            end else begin
               res[c] = m3_ff[c][CHAN_W-1:0];
            end
         end
         out4_in.red_out       = res[0];
         out4_in.green_out     = res[1];
         out4_in.blue_out      = res[2];
         out4_in.alpha_out     = pix3_ff.alpha_in;
         out4_in.image_end_out = pix3_ff.image_end_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      pix1_ff <= pix1_in;
      lum1_ff <= lum1_in;
      pix2_ff <= pix2_in;
      lum2_ff <= lum2_in;
      pix3_ff <= pix3_in;
      lo3_ff  <= lo3_in;
      hi3_ff  <= hi3_in;
      out4_ff <= out4_in;
      for (int c = 0; c < NUM_CHAN; c++) begin
         opd1_ff[c]  <= opd1_in[c];
         prod2_ff[c] <= prod2_in[c];
         m3_ff[c]    <= m3_in[c];
      end
   end

   // ---------------------------------------------------------------- assertions
   // input stall only comes from a full first stage
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("req_stall with empty first stage");

   // a stalled output holds stage 3 in place
   a_stage3_held: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && rsp_stall && v3_ff) |=> v3_ff)
      else $error("stage 3 transaction lost under stall");

   // a channel cannot clamp both low and high
   a_clamp_excl: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((lo3_ff & hi3_ff) == '0))
      else $error("channel flagged for both clamp limits");

   // transactions entering an empty pipeline reach the output while the result side does not stall
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall && !v1_ff && !v2_ff && !v3_ff && !v4_ff)
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("transaction did not reach the output in four cycles");

endmodule

`default_nettype wire

// ===== tb/sv/tb_pixel_color_adjust.sv =====
// self-checking testbench for the pixel color adjuster: scoreboard against an exact predictor
`default_nettype none

module tb_pixel_color_adjust;

   timeunit 1ns;
   timeprecision 1ps;

   import pca_pkg::*;

   // pipeline depth given at the head of the block, plus some slack for the final wait
   localparam int PIPE_DEPTH   = 4;
   localparam int SETTLE_WAIT  = PIPE_DEPTH + 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 200;
   localparam int RESET_CYCLES = 10;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // block inputs, all known from time zero
   logic                   req_valid = 1'b0;
   pix_in_type             req_data  = '0;
   logic                   rsp_stall = 1'b0;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MODE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // block outputs
   logic        req_stall;
   logic        rsp_valid;
   pix_out_type rsp_data;

   pixel_color_adjust dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the csr registers, reset values
   adjust_mode_type             shadow_mode   = MODE_PASS;
   logic signed [FACTOR_W-1:0] shadow_factor = FACTOR_ONE;

   // pixels predicted for every accepted input transaction, oldest first
   pix_out_type expected_pixels[$];

   int error_count   = 0;
   int pixels_seen   = 0;
   int cycle_count   = 0;

   // idle rates in percent, changed per test phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // request for a long receiver hold-off
   logic hold_start = 1'b0;

   // ---------------------------------------------------------------------------------------
   // predictor: exact floor of the adjusted value, clamped to one byte
   // ---------------------------------------------------------------------------------------

   // floor division for a positive divisor
   function automatic longint div_floor(input longint num, input longint den);
      longint quo;
      quo = num / den;
      if ((num % den) != 0 && num < 0) quo = quo - 1;
      return quo;
   endfunction

   function automatic logic [CHAN_W-1:0] adjust_value(input logic [CHAN_W-1:0] x,
                                                      input longint lum,
                                                      input adjust_mode_type mode,
                                                      input logic signed [FACTOR_W-1:0] f);
      longint xi;
      longint fi;
      longint one;
      longint v;
      xi  = x;
      fi  = f;
      one = longint'(1) <<< FRACTION_BITS;
      case (mode)
         MODE_BRIGHT:   v = div_floor(xi * fi, one);
         // pivot around the midpoint 127.5, doubled to stay in integers
         MODE_CONTRAST: v = div_floor(255 * one + fi * (2 * xi - 255), 2 * one);
         // lerp from luminance (weights scaled by ten thousand) toward the channel
         MODE_SATURATE: v = div_floor((one - fi) * lum + fi * xi * LUM_SCALE,
                                      one * LUM_SCALE);
         default:       v = xi;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CHAN_W'(v);
   endfunction

   function automatic pix_out_type predict_pixel(input pix_in_type px,
                                                 input adjust_mode_type mode,
                                                 input logic signed [FACTOR_W-1:0] f);
      pix_out_type res;
      longint      lum;
      lum = LUM_R * longint'(px.red_in) + LUM_G * longint'(px.green_in)
          + LUM_B * longint'(px.blue_in);
      res.red_out       = adjust_value(px.red_in,   lum, mode, f);
      res.green_out     = adjust_value(px.green_in, lum, mode, f);
      res.blue_out      = adjust_value(px.blue_in,  lum, mode, f);
      res.alpha_out     = px.alpha_in;
      res.image_end_out = px.image_end_in;
      return res;
   endfunction

   // ---------------------------------------------------------------------------------------
   // result side: stall generator and checker
   // ---------------------------------------------------------------------------------------

   // random stall, or a long hold-off when requested; the hold is counted here
   always @(posedge clock) begin : rsp_stall_gen
      int hold_left;
      if (hold_start) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic report_error(input string msg);
      $display("error at cycle %0d: %s", cycle_count, msg);
      error_count = error_count + 1;
   endtask

   task automatic compare_field(input string name, input logic [CHAN_W-1:0] got,
                                input logic [CHAN_W-1:0] want);
      if (got !== want)
         report_error($sformatf("pixel %0d %s got %0h want %0h", pixels_seen, name, got, want));
   endtask

   // values seen at the edge are the ones that held before it, so no ordering race
   always @(posedge clock) begin : pixel_checker
      pix_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_error($sformatf("unexpected result transaction %0h", rsp_data));
         end else begin
            want = expected_pixels.pop_front();
            compare_field("red",       rsp_data.red_out,       want.red_out);
            compare_field("green",     rsp_data.green_out,     want.green_out);
            compare_field("blue",      rsp_data.blue_out,      want.blue_out);
            compare_field("alpha",     rsp_data.alpha_out,     want.alpha_out);
            compare_field("image_end", CHAN_W'(rsp_data.image_end_out),
                          CHAN_W'(want.image_end_out));
         end
         pixels_seen = pixels_seen + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // input side helpers
   // ---------------------------------------------------------------------------------------

   // offer one pixel, optionally after a random gap, and wait until it is taken
   task automatic send_pixel(input pix_in_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // taken at this edge, so the prediction uses the settings in force now
      expected_pixels.push_back(predict_pixel(px, shadow_mode, shadow_factor));
   endtask

   // stop offering and wait for the pipeline to run empty
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == CSR_MODE) shadow_mode = adjust_mode_type'(data[MODE_W-1:0]);
      else shadow_factor = data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // mode goes in with random upper bits, which the block must ignore
   task automatic apply_settings(input adjust_mode_type mode,
                                 input logic signed [FACTOR_W-1:0] f);
      logic [CSR_DATA_W-1:0] mode_word;
      drain_pipeline();
      mode_word = CSR_DATA_W'($urandom);
      mode_word[MODE_W-1:0] = mode;
      write_csr(CSR_MODE, mode_word);
      write_csr(CSR_FACTOR, f);
   endtask

   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return CHAN_MAX;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   function automatic pix_in_type random_pixel();
      pix_in_type px;
      px.red_in       = random_channel();
      px.green_in     = random_channel();
      px.blue_in      = random_channel();
      px.alpha_in     = CHAN_W'($urandom);
      px.image_end_in = ($urandom_range(15) == 0);
      return px;
   endfunction

   // a few fixed pixels: all black, all white, mixed extremes, near-extremes
   task automatic send_corner_pixels();
      send_pixel('{8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
      send_pixel('{8'hff, 8'hff, 8'hff, 8'hff, 1'b1});
      send_pixel('{8'hff, 8'h00, 8'h80, 8'h5a, 1'b0});
      send_pixel('{8'h01, 8'hfe, 8'h7f, 8'ha5, 1'b1});
   endtask

   function automatic logic signed [FACTOR_W-1:0] random_factor();
      case ($urandom_range(5))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         2:       return '0;
         3:       return FACTOR_ONE;
         4:       return FACTOR_W'($urandom_range(2 * (1 << FRACTION_BITS)));
         default: return FACTOR_W'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // registers as they come out of reset: pass-through with factor one
   task automatic test_reset_defaults();
      send_idle_pct = 21;
      recv_idle_pct = 76;
      send_corner_pixels();
   endtask

   // brighten, contrast and saturate with factors at the ends of the range, zero factor included
   task automatic test_mode_extremes();
      apply_settings(MODE_BRIGHT,   16'sd32767);
      send_corner_pixels();
      apply_settings(MODE_BRIGHT,   -16'sd32768);
      send_corner_pixels();
      apply_settings(MODE_CONTRAST, 16'sd32767);
      send_corner_pixels();
      // zero saturation leaves only luminance
      apply_settings(MODE_SATURATE, '0);
      send_corner_pixels();
      apply_settings(MODE_SATURATE, -16'sd32768);
      send_corner_pixels();
   endtask

   // random pixels under a run of settings, every mode in each run
   task automatic test_random_settings(input int send_pct, input int recv_pct,
                                       input int num_settings, input int pixels_each);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int s = 0; s < num_settings; s++) begin
         apply_settings(adjust_mode_type'(s % 4), random_factor());
         repeat (pixels_each) send_pixel(random_pixel());
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering,
   // so the pipeline fills and req_stall has to rise
   task automatic test_back_pressure();
      apply_settings(MODE_CONTRAST, random_factor());
      send_idle_pct = 0;
      recv_idle_pct = 30;
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      repeat (40) send_pixel(random_pixel());
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_mode_extremes();
      test_random_settings(21, 76, 4, 40);
      test_random_settings(76, 21, 4, 40);
      test_random_settings(0, 0, 4, 40);
      test_back_pressure();
      drain_pipeline();

      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
